### design/sha_pkg.sv
package sha_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] r;
    unique case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] v, input int r);
    return (v >> r) | (v << (32 - r));
  endfunction

endpackage

### design/sha256_byte_stream_hasher.sv
// A byte that does not fill a block is taken while idle; the byte that fills a
// block stalls the input through load, the rounds, done and fold.
// End of message: 1-2 padded blocks, each through pad, load, rounds, done and
// fold, then 8 digest words, one per cycle when not stalled.
// The input stays stalled while a block is hashed or the digest is sent.
// Reset (rst, synchronous): initial hash values, zero count, idle.
module sha256_byte_stream_hasher
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  state_t       state, state_next;
  logic [31:0]  buf_mem [16];
  logic [5:0]   fill;
  logic [63:0]  bit_len;
  logic [31:0]  chain [8];
  logic         fin, second, padded;
  logic [2:0]   oidx;
  logic         rreq, rstart, rdone;
  logic [511:0] blk;
  logic [255:0] chain_flat, work;
  logic         acc;

  assign acc = in_valid && !in_stall;

  always_comb begin
    for (int i = 0; i < 8; i++) chain_flat[255 - 32*i -: 32] = chain[i];
    for (int i = 0; i < 16; i++) blk[511 - 32*i -: 32] = buf_mem[i];
  end

  sha_round u_round (
    .clk(clk), .rst(rst), .start(rstart), .block(blk),
    .chain_in(chain_flat), .work(work), .done(rdone)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          if (has_byte && fill == 6'd63) state_next = ST_ROUND;
          else if (is_last) state_next = ST_PAD;
        end
      end
      ST_PAD:   state_next = ST_ROUND;
      ST_ROUND: if (rdone) state_next = ST_FOLD;
      ST_FOLD: begin
        if (fin) state_next = (second || !padded) ? ST_PAD : ST_OUT;
        else state_next = ST_IDLE;
      end
      ST_OUT: if (!out_stall && oidx == 3'd7) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != ST_IDLE);
    out_valid = (state == ST_OUT);
    rreq      = 1'b0;
    unique case (state)
      ST_IDLE:  rreq = acc && has_byte && fill == 6'd63;
      ST_PAD:   rreq = 1'b1;
      default:  rreq = 1'b0;
    endcase
  end

  assign digest_word = chain[oidx];
  assign word_index  = oidx;
  assign last_word   = (oidx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      fill    <= '0;
      bit_len <= '0;
      fin     <= 1'b0;
      second  <= 1'b0;
      padded  <= 1'b0;
      rstart  <= 1'b0;
      oidx    <= '0;
      for (int i = 0; i < 8; i++) chain[i] <= init_hash(3'(i));
    end else begin
      state  <= state_next;
      rstart <= rreq;
      unique case (state)
        ST_IDLE: begin
          if (acc) begin
            if (has_byte) begin
              fill    <= fill + 6'd1;
              bit_len <= bit_len + 64'd8;
            end
            fin <= is_last;
          end
        end
        ST_PAD: begin
          // buffer fill for this pass; second marks a count-only block to follow
          second <= (fill >= LEN_POS) && !second;
          padded <= 1'b1;
          fill   <= '0;
        end
        ST_FOLD: begin
          for (int i = 0; i < 8; i++)
            chain[i] <= chain[i] + work[255 - 32*i -: 32];
        end
        ST_OUT: begin
          if (!out_stall) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd7) begin
              fin     <= 1'b0;
              padded  <= 1'b0;
              bit_len <= '0;
              for (int i = 0; i < 8; i++) chain[i] <= init_hash(3'(i));
            end
          end
        end
        default: ;
      endcase
    end
  end

  // second flag: set in PAD on first pass means fill was >=56, 0x80 already
  // placed; the next PAD pass writes zeros then the length.
  logic tail_pass;
  assign tail_pass = second;

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && acc && has_byte)
      buf_mem[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= data_byte;
    if (state == ST_PAD) begin
      for (int i = 0; i < 64; i++) begin
        if (tail_pass) begin
          buf_mem[i[5:2]][8*(3 - i[1:0]) +: 8] <=
            (i >= 56) ? bit_len[63 - 8*(i % 8) -: 8] : 8'h00;
        end else if (6'(i) == fill) begin
          buf_mem[i[5:2]][8*(3 - i[1:0]) +: 8] <= PAD_BYTE;
        end else if (6'(i) > fill) begin
          if (fill >= LEN_POS || i < 56) buf_mem[i[5:2]][8*(3 - i[1:0]) +: 8] <= 8'h00;
          else buf_mem[i[5:2]][8*(3 - i[1:0]) +: 8] <= bit_len[63 - 8*(i % 8) -: 8];
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> fin)
    else $error("digest without end of message");
  assert property (@(posedge clk) disable iff (rst) rstart |-> !rdone)
    else $error("round unit restarted at completion");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && !out_stall && oidx == 3'd7) |=> fill == 6'd0 && bit_len == 64'd0)
    else $error("state not cleared after digest");

endmodule

### design/sha_round.sv
module sha_round
  import sha_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [511:0] block,
  input  logic [255:0] chain_in,
  output logic [255:0] work,
  output logic         done
);

  logic [31:0] w [16];
  logic [31:0] v [8];
  logic [5:0]  rnd;
  logic        busy;
  logic [31:0] w_new, t1, t2, e, a;

  always_comb begin
    w_new = (rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10)) + w[9]
          + (rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3)) + w[0];
    e = v[4];
    a = v[0];
    t1 = v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
       + ((e & v[5]) ^ (~e & v[6])) + ROUND_K[rnd] + w[0];
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
       + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      rnd  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rnd  <= '0;
      end else if (busy) begin
        rnd <= rnd + 6'd1;
        if (rnd == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < 16; i++) w[i] <= block[511 - 32*i -: 32];
      for (int i = 0; i < 8; i++) v[i] <= chain_in[255 - 32*i -: 32];
    end else if (busy) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= w_new;
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) work[255 - 32*i -: 32] = v[i];
  end

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("round done while busy");
  assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("round did not start");
  assert property (@(posedge clk) disable iff (rst) busy && rnd == 6'd63 |=> done)
    else $error("round count slip");

endmodule

### tb/sv/sha256_checker.sv
module sha256_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        is_last,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] digest_word,
  input  logic [2:0]  word_index,
  input  logic        last_word,
  output int          fail_count,
  output int          pending_words
);
  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };
  localparam logic [31:0] KTAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  logic [31:0]  hash_state [8];
  logic [7:0]   msg_block [64];
  logic [5:0]   fill;
  logic [63:0]  bit_count;
  digest_word_t digest_q [$];

  assign pending_words = digest_q.size();

  function automatic logic [31:0] ror(logic [31:0] v, int r);
    return (v >> r) | (v << (32 - r));
  endfunction

  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    for (int t = 16; t < 64; t++)
      w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
           + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
    {a, b, c, d, e, f, g, h} = {hash_state[0], hash_state[1], hash_state[2],
      hash_state[3], hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
    for (int t = 0; t < 64; t++) begin
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
         + KTAB[t] + w[t];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endtask

  task automatic absorb_word(logic [7:0] db, logic hb, logic il);
    int pos;
    digest_word_t dw;
    if (hb) begin
      msg_block[fill] = db;
      bit_count += 64'd8;
      fill++;
      if (fill == 0) compress();
    end
    if (il) begin
      pos = fill;
      msg_block[pos++] = 8'h80;
      if (pos > 56) begin
        while (pos < 64) msg_block[pos++] = 8'h00;
        compress();
        pos = 0;
      end
      while (pos < 56) msg_block[pos++] = 8'h00;
      for (int j = 0; j < 8; j++) msg_block[56+j] = bit_count[63-8*j -: 8];
      compress();
      for (int j = 0; j < 8; j++) begin
        dw.word = hash_state[j];
        dw.idx = 3'(j);
        dw.last = (j == 7);
        digest_q.push_back(dw);
      end
      hash_state = IV;
      fill = '0;
      bit_count = '0;
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    hash_state = IV;
    fill = '0;
    bit_count = '0;
    foreach (msg_block[i]) msg_block[i] = '0;
  end

  always @(posedge clk) begin
    digest_word_t exp_w;
    if (!rst) begin
      if (in_valid && !in_stall) absorb_word(data_byte, has_byte, is_last);
      if (out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          report("unexpected word", digest_word, 32'd0);
        end else begin
          exp_w = digest_q.pop_front();
          if (digest_word !== exp_w.word) report("digest_word", digest_word, exp_w.word);
          if (word_index !== exp_w.idx)
            report("word_index", 32'(word_index), 32'(exp_w.idx));
          if (last_word !== exp_w.last)
            report("last_word", 32'(last_word), 32'(exp_w.last));
        end
      end
    end
  end
endmodule

### tb/sv/tb_top.sv
module tb_top;
  logic        clk, rst;
  logic        in_valid, in_stall;
  logic [7:0]  data_byte;
  logic        has_byte, is_last;
  logic        out_valid, out_stall;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  int          fail_count, pending_words;
  int          send_idle_pct, recv_stall_pct;

  sha256_byte_stream_hasher DUT (.*);

  sha256_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("TB_ERROR");
    $finish;
  end

  always @(negedge clk)
    out_stall <= ($urandom_range(99) < recv_stall_pct);

  task automatic send_word(logic [7:0] db, logic hb, logic il);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    data_byte <= db;
    has_byte <= hb;
    is_last <= il;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_message(int len, bit end_alone);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) send_word(8'($urandom), 0, 0);
      send_word(8'($urandom), 1, !end_alone && i == len - 1);
    end
    if (end_alone || len == 0) send_word(8'($urandom), 0, 1);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending_words != 0) @(negedge clk);
  endtask

  initial begin
    int len;
    in_valid = 0; data_byte = 0; has_byte = 0; is_last = 0; out_stall = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    rst = 1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;
    // directed
    send_word(8'h00, 0, 0);
    send_word(8'hff, 0, 1);
    send_word(8'hff, 1, 1);
    send_word(8'h00, 1, 1);
    for (int i = 0; i < 3; i++) send_word(8'(8'h61 + i), 1, i == 2);
    for (int i = 0; i < 4; i++) send_word(8'h55 ^ {8{i[0]}}, 1, 0);
    send_word(8'haa, 0, 0);
    send_word(8'h00, 0, 1);
    drain();
    // random phases
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 82 : 30) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 82 : 30) : 0;
      for (int m = 0; m < 2; m++) begin
        case ($urandom_range(7))
          0: len = $urandom_range(54, 57);
          1: len = $urandom_range(62, 65);
          2: len = 0;
          default: len = $urandom_range(1, 12);
        endcase
        send_message(len, 1'($urandom_range(1)));
      end
      if (ph == 1) drain();
    end
    drain();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

### filelist.f
design/sha_pkg.sv
design/sha_round.sv
design/sha256_byte_stream_hasher.sv
tb/sv/sha256_checker.sv
tb/sv/tb_top.sv
